// ===== hdl/wpool_pkg.sv =====
// ----------------------------------------------------------------------------
// wpool_pkg
// Shared types and constants for the window pooling core.
// ----------------------------------------------------------------------------
package wpool_pkg;

  localparam int PIXEL_W        = 16;
  localparam int CFG_DATA_W     = 11;
  localparam int CFG_IDX_W      = 3;
  localparam int POS_W          = 10;
  localparam int STRIDE_W       = 4;
  localparam int WIN_REG_W      = 4;
  localparam int MAX_HEIGHT     = 1024;
  localparam int MAX_MAPS       = 1024;
  localparam int DEF_MAX_WINDOW = 8;
  localparam int DEF_MAX_WIDTH  = 1024;

  localparam logic                 RST_POOL_MODE = 1'b0;
  localparam logic [WIN_REG_W-1:0] RST_WINDOW    = 4'd2;
  localparam logic [STRIDE_W-1:0]  RST_STRIDE    = 4'd2;
  localparam logic [CFG_DATA_W-1:0] RST_WIDTH    = 11'd32;
  localparam logic [CFG_DATA_W-1:0] RST_HEIGHT   = 11'd32;
  localparam logic [CFG_DATA_W-1:0] RST_MAPS     = 11'd1;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_POOL_MODE   = 3'd0,
    REG_WINDOW_SIZE = 3'd1,
    REG_STRIDE_STEP = 3'd2,
    REG_MAP_WIDTH   = 3'd3,
    REG_MAP_HEIGHT  = 3'd4,
    REG_MAP_COUNT   = 3'd5
  } reg_idx_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_COL,
    ST_CHECK,
    ST_EMIT,
    ST_DIV
  } state_t;

  typedef struct packed {
    logic accept;
    logic col_step;
    logic check;
    logic div_start;
    logic load_out;
  } cmd_t;

  typedef struct packed {
    logic win_cand;
    logic aligned;
    logic avg_mode;
    logic div_busy;
    logic out_free;
  } status_t;

endpackage

// ===== hdl/wpool_div.sv =====
// ----------------------------------------------------------------------------
// wpool_div
// Signed by unsigned restoring divider, one quotient bit per cycle,
// quotient truncated toward zero.
// ----------------------------------------------------------------------------
module wpool_div #(
  parameter int W  = 22,
  parameter int DW = 8
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  input  logic signed [W-1:0] dividend,
  input  logic [DW-1:0]       divisor,
  output logic                busy,
  output logic signed [W-1:0] quotient
);

  localparam int CW = $clog2(W + 1);

  logic [CW-1:0] cnt;
  logic [W-1:0]  quo;
  logic [DW-1:0] rem;
  logic [DW-1:0] dvs;
  logic          neg;
  logic [DW:0]   rem_sh;
  logic          fits;

  assign busy   = (cnt != '0);
  assign rem_sh = {rem, quo[W-1]};
  assign fits   = (rem_sh >= {1'b0, dvs});

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
    end else if (start) begin
      cnt <= CW'(W);
    end else if (busy) begin
      cnt <= cnt - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      neg <= dividend[W-1];
      quo <= dividend[W-1] ? W'(-dividend) : W'(dividend);
      rem <= '0;
      dvs <= divisor;
    end else if (busy) begin
      rem <= fits ? DW'(rem_sh - {1'b0, dvs}) : rem_sh[DW-1:0];
      quo <= {quo[W-2:0], fits};
    end
  end

  assign quotient = neg ? -$signed(quo) : $signed(quo);

endmodule

// ===== hdl/wpool_dp.sv =====
// ----------------------------------------------------------------------------
// wpool_dp
// Pooling datapath: configuration registers, raster position, banked line
// store, column and window reduction, divider and output register.
// ----------------------------------------------------------------------------
module wpool_dp #(
  parameter int MAX_WINDOW = 8,
  parameter int MAX_WIDTH  = 1024
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_we,
  input  logic [wpool_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [wpool_pkg::CFG_DATA_W-1:0]    cfg_data,
  input  logic signed [wpool_pkg::PIXEL_W-1:0] pixel_value,
  input  wpool_pkg::cmd_t                     cmd,
  output wpool_pkg::status_t                  status,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic signed [wpool_pkg::PIXEL_W-1:0] pooled_value,
  output logic [wpool_pkg::POS_W-1:0]         out_row,
  output logic [wpool_pkg::POS_W-1:0]         out_col,
  output logic                                last_of_map,
  output logic                                last_of_all
);

  import wpool_pkg::*;

  localparam int LR     = (MAX_WINDOW > 1) ? MAX_WINDOW - 1 : 1;
  localparam int RS_W   = (LR > 1) ? $clog2(LR) : 1;
  localparam int CS_W   = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
  localparam int COL_W  = $clog2(MAX_WIDTH);
  localparam int WIN_W  = $clog2(MAX_WINDOW + 1);
  localparam int PART_W = PIXEL_W + 2 * $clog2(MAX_WINDOW);
  localparam int AREA_W = 2 * WIN_W;
  localparam int QN     = (COL_W > POS_W) ? COL_W : POS_W;
  localparam int RK     = QN + 5;
  localparam int PW_W   = ((COL_W > CFG_DATA_W) ? COL_W : CFG_DATA_W) + 2;
  localparam int HW     = CFG_DATA_W + 1;

  // ceil(2^RK / d): exact quotient by multiply and shift for QN-bit numerators
  typedef logic [RK:0] recip_t;
  localparam recip_t RECIP [16] = '{
    recip_t'(0),
    recip_t'((2**RK + 0) / 1),   recip_t'((2**RK + 1) / 2),
    recip_t'((2**RK + 2) / 3),   recip_t'((2**RK + 3) / 4),
    recip_t'((2**RK + 4) / 5),   recip_t'((2**RK + 5) / 6),
    recip_t'((2**RK + 6) / 7),   recip_t'((2**RK + 7) / 8),
    recip_t'((2**RK + 8) / 9),   recip_t'((2**RK + 9) / 10),
    recip_t'((2**RK + 10) / 11), recip_t'((2**RK + 11) / 12),
    recip_t'((2**RK + 12) / 13), recip_t'((2**RK + 13) / 14),
    recip_t'((2**RK + 14) / 15)
  };

  // configuration
  logic                  cfg_mode;
  logic [WIN_REG_W-1:0]  cfg_win;
  logic [STRIDE_W-1:0]   cfg_stride;
  logic [CFG_DATA_W-1:0] cfg_width;
  logic [CFG_DATA_W-1:0] cfg_height;
  logic [CFG_DATA_W-1:0] cfg_maps;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg_mode   <= RST_POOL_MODE;
      cfg_win    <= RST_WINDOW;
      cfg_stride <= RST_STRIDE;
      cfg_width  <= RST_WIDTH;
      cfg_height <= RST_HEIGHT;
      cfg_maps   <= RST_MAPS;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_POOL_MODE:   cfg_mode   <= cfg_data[0];
        REG_WINDOW_SIZE: cfg_win    <= cfg_data[WIN_REG_W-1:0];
        REG_STRIDE_STEP: cfg_stride <= cfg_data[STRIDE_W-1:0];
        REG_MAP_WIDTH:   cfg_width  <= cfg_data;
        REG_MAP_HEIGHT:  cfg_height <= cfg_data;
        REG_MAP_COUNT:   cfg_maps   <= cfg_data;
        default: ;
      endcase
    end
  end

  // clamped settings
  logic [WIN_W-1:0]      win_e;
  logic [STRIDE_W-1:0]   str_e;
  logic [CFG_DATA_W-1:0] w_e;
  logic [CFG_DATA_W-1:0] h_e;
  logic [CFG_DATA_W-1:0] n_e;

  always_comb begin
    if (cfg_win == '0)                   win_e = WIN_W'(1);
    else if (int'(cfg_win) > MAX_WINDOW) win_e = WIN_W'(MAX_WINDOW);
    else                                 win_e = WIN_W'(cfg_win);
    str_e = (cfg_stride == '0) ? STRIDE_W'(1) : cfg_stride;
    if (cfg_width == '0)                  w_e = CFG_DATA_W'(1);
    else if (int'(cfg_width) > MAX_WIDTH) w_e = CFG_DATA_W'(MAX_WIDTH);
    else                                  w_e = cfg_width;
    if (cfg_height == '0)                  h_e = CFG_DATA_W'(1);
    else if (int'(cfg_height) > MAX_HEIGHT) h_e = CFG_DATA_W'(MAX_HEIGHT);
    else                                   h_e = cfg_height;
    if (cfg_maps == '0)                  n_e = CFG_DATA_W'(1);
    else if (int'(cfg_maps) > MAX_MAPS)  n_e = CFG_DATA_W'(MAX_MAPS);
    else                                 n_e = cfg_maps;
  end

  // raster position, with row slot of the line store and partial slot
  logic [COL_W-1:0] col_pos;
  logic [POS_W-1:0] row_pos;
  logic [POS_W-1:0] map_pos;
  logic [RS_W-1:0]  rslot;
  logic [CS_W-1:0]  cslot;

  logic [COL_W-1:0] col_next;
  logic [POS_W-1:0] row_next;
  logic [POS_W-1:0] map_next;
  logic [RS_W-1:0]  rslot_next;
  logic [CS_W-1:0]  cslot_next;

  // accept wraps stale positions, a column step advances by one pixel
  always_comb begin
    logic [PW_W-1:0] n_col;
    logic [HW-1:0]   n_row;
    logic [HW-1:0]   n_map;
    logic [RS_W-1:0] n_rs;
    logic [CS_W-1:0] n_cs;
    n_col = cmd.col_step ? PW_W'(col_pos) + 1'b1 : PW_W'(col_pos);
    if (!cmd.col_step)                           n_cs = cslot;
    else if (cslot == CS_W'(MAX_WINDOW - 1))     n_cs = '0;
    else                                         n_cs = cslot + 1'b1;
    n_row = HW'(row_pos);
    n_map = HW'(map_pos);
    n_rs  = rslot;
    if (n_col >= PW_W'(w_e)) begin
      n_col = '0;
      n_cs  = '0;
      n_row = n_row + 1'b1;
      n_rs  = (rslot == RS_W'(LR - 1)) ? '0 : rslot + 1'b1;
    end
    if (n_row >= HW'(h_e)) begin
      n_row = '0;
      n_rs  = '0;
      n_map = n_map + 1'b1;
    end
    if (n_map >= HW'(n_e)) begin
      n_map = '0;
    end
    col_next   = n_col[COL_W-1:0];
    row_next   = n_row[POS_W-1:0];
    map_next   = n_map[POS_W-1:0];
    rslot_next = n_rs;
    cslot_next = n_cs;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      col_pos <= '0;
      row_pos <= '0;
      map_pos <= '0;
      rslot   <= '0;
      cslot   <= '0;
    end else if (cmd.accept || cmd.col_step) begin
      col_pos <= col_next;
      row_pos <= row_next;
      map_pos <= map_next;
      rslot   <= rslot_next;
      cslot   <= cslot_next;
    end
  end

  logic signed [PIXEL_W-1:0] pix;

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      pix <= pixel_value;
    end
  end

  // line store: one bank per stored row, all read at the same column
  logic signed [PIXEL_W-1:0] rd_data [LR];

  for (genvar b = 0; b < LR; b++) begin : g_bank
    logic signed [PIXEL_W-1:0] mem [MAX_WIDTH];
    always_ff @(posedge clk) begin
      if (cmd.col_step && rslot == RS_W'(b)) begin
        mem[col_pos] <= pix;
      end
      rd_data[b] <= mem[col_next];
    end
  end

  // column reduction
  logic signed [PART_W-1:0] col_acc;

  always_comb begin
    int                       s;
    logic [RS_W-1:0]          slot;
    logic signed [PART_W-1:0] v;
    col_acc = PART_W'(pix);
    for (int k = 1; k < MAX_WINDOW; k++) begin
      s = int'(rslot) - k;
      if (s < 0) s = s + LR;
      slot = RS_W'(s);
      v    = PART_W'(rd_data[slot]);
      if (k < int'(win_e)) begin
        if (cfg_mode)      col_acc = col_acc + v;
        else if (v > col_acc) col_acc = v;
      end
    end
  end

  // position tests and output coordinates for the current pixel
  logic [HW-1:0]          row1;
  logic [PW_W-1:0]        col1;
  logic                   col_full;
  logic [QN-1:0]          r0;
  logic [QN-1:0]          c0;
  logic [QN+RK:0]         prod_r;
  logic [QN+RK:0]         prod_c;
  logic                   lom;

  assign row1     = HW'(row_pos) + 1'b1;
  assign col1     = PW_W'(col_pos) + 1'b1;
  assign col_full = (row1 >= HW'(win_e));
  assign r0       = QN'(row1 - HW'(win_e));
  assign c0       = QN'(col1 - PW_W'(win_e));
  assign prod_r   = (QN+RK+1)'(r0) * (QN+RK+1)'(RECIP[str_e]);
  assign prod_c   = (QN+RK+1)'(c0) * (QN+RK+1)'(RECIP[str_e]);
  assign lom      = ((HW + 1)'(row1) + (HW + 1)'(str_e) > (HW + 1)'(h_e)) &&
                    (col1 + PW_W'(str_e) > PW_W'(w_e));

  logic [QN-1:0]   q_row;
  logic [QN-1:0]   q_col;
  logic [QN-1:0]   r0_q;
  logic [QN-1:0]   c0_q;
  logic            lom_q;
  logic            loa_q;
  logic [CS_W-1:0] pslot;

  logic signed [PART_W-1:0] part [MAX_WINDOW];

  // keep the partial slot of this pixel, cslot moves on with the column step
  always_ff @(posedge clk) begin
    if (cmd.col_step) begin
      q_row <= prod_r[RK +: QN];
      q_col <= prod_c[RK +: QN];
      r0_q  <= r0;
      c0_q  <= c0;
      lom_q <= lom;
      loa_q <= lom && (HW'(map_pos) + 1'b1 == HW'(n_e));
      pslot <= cslot;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < MAX_WINDOW; i++) part[i] <= '0;
    end else if (cmd.col_step && col_full) begin
      part[cslot] <= col_acc;
    end
  end

  // window reduction over the last win_e column partials
  logic signed [PART_W-1:0] win_acc;
  logic signed [PART_W-1:0] win_res;

  always_comb begin
    int                       s;
    logic [CS_W-1:0]          idx;
    logic signed [PART_W-1:0] v;
    win_acc = part[pslot];
    for (int k = 1; k < MAX_WINDOW; k++) begin
      s = int'(pslot) - k;
      if (s < 0) s = s + MAX_WINDOW;
      idx = CS_W'(s);
      v   = part[idx];
      if (k < int'(win_e)) begin
        if (cfg_mode)         win_acc = win_acc + v;
        else if (v > win_acc) win_acc = v;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.check) begin
      win_res <= win_acc;
    end
  end

  logic aligned;
  assign aligned = ((QN+STRIDE_W)'(q_row) * (QN+STRIDE_W)'(str_e) ==
                    (QN+STRIDE_W)'(r0_q)) &&
                   ((QN+STRIDE_W)'(q_col) * (QN+STRIDE_W)'(str_e) ==
                    (QN+STRIDE_W)'(c0_q));

  // average: divide the window sum by the window area
  logic [AREA_W-1:0]        area;
  logic                     div_busy;
  logic signed [PART_W-1:0] div_q;

  assign area = AREA_W'(win_e) * AREA_W'(win_e);

  wpool_div #(
    .W  (PART_W),
    .DW (AREA_W)
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.div_start),
    .dividend (win_res),
    .divisor  (area),
    .busy     (div_busy),
    .quotient (div_q)
  );

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      pooled_value <= cfg_mode ? div_q[PIXEL_W-1:0] : win_res[PIXEL_W-1:0];
      out_row      <= q_row[POS_W-1:0];
      out_col      <= q_col[POS_W-1:0];
      last_of_map  <= lom_q;
      last_of_all  <= loa_q;
    end
  end

  always_comb begin
    status.win_cand = col_full && (col1 >= PW_W'(win_e));
    status.aligned  = aligned;
    status.avg_mode = cfg_mode;
    status.div_busy = div_busy;
    status.out_free = !out_valid || out_ready;
  end

endmodule

// ===== hdl/wpool_ctrl.sv =====
// ----------------------------------------------------------------------------
// wpool_ctrl
// Sequencer for the pooling datapath: accept, column step, window check,
// result emission.
// ----------------------------------------------------------------------------
module wpool_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  wpool_pkg::status_t status,
  output wpool_pkg::cmd_t    cmd
);

  import wpool_pkg::*;

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    in_ready   = 1'b0;
    case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.accept = 1'b1;
          state_next = ST_COL;
        end
      end
      ST_COL: begin
        cmd.col_step = 1'b1;
        state_next   = status.win_cand ? ST_CHECK : ST_IDLE;
      end
      ST_CHECK: begin
        cmd.check  = 1'b1;
        state_next = status.aligned ? ST_EMIT : ST_IDLE;
      end
      ST_EMIT: begin
        if (status.avg_mode) begin
          cmd.div_start = 1'b1;
          state_next    = ST_DIV;
        end else if (status.out_free) begin
          cmd.load_out = 1'b1;
          state_next   = ST_IDLE;
        end
      end
      ST_DIV: begin
        // hold until the quotient is ready and the output slot is free
        if (!status.div_busy && status.out_free) begin
          cmd.load_out = 1'b1;
          state_next   = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

// ===== hdl/window_pooling_max_avg_core.sv =====
// ----------------------------------------------------------------------------
// window_pooling_max_avg_core
// Max and average pooling over a raster stream of signed Q8.8 feature maps.
// ----------------------------------------------------------------------------
// A pixel that cannot close a window is accepted, then goes through the line
// store read and column reduce; one that can close a window also takes the
// stride alignment check. A max result then loads the output register; an
// average result first runs the restoring divider, one quotient bit a cycle.
// A new pixel is accepted only once the last one is through and the sequencer
// is back in idle. The output register holds a finished result while the next
// pixel is accepted; a second result waits only if the first has not been taken.
module window_pooling_max_avg_core #(
  parameter int MAX_WINDOW = wpool_pkg::DEF_MAX_WINDOW,
  parameter int MAX_WIDTH  = wpool_pkg::DEF_MAX_WIDTH
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 cfg_we,
  input  logic [wpool_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [wpool_pkg::CFG_DATA_W-1:0]     cfg_data,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  logic signed [wpool_pkg::PIXEL_W-1:0] pixel_value,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic signed [wpool_pkg::PIXEL_W-1:0] pooled_value,
  output logic [wpool_pkg::POS_W-1:0]          out_row,
  output logic [wpool_pkg::POS_W-1:0]          out_col,
  output logic                                 last_of_map,
  output logic                                 last_of_all
);

  import wpool_pkg::*;

  cmd_t    cmd;
  status_t status;

  wpool_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .status   (status),
    .cmd      (cmd)
  );

  wpool_dp #(
    .MAX_WINDOW (MAX_WINDOW),
    .MAX_WIDTH  (MAX_WIDTH)
  ) u_dp (
    .clk          (clk),
    .rst          (rst),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .pixel_value  (pixel_value),
    .cmd          (cmd),
    .status       (status),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .pooled_value (pooled_value),
    .out_row      (out_row),
    .out_col      (out_col),
    .last_of_map  (last_of_map),
    .last_of_all  (last_of_all)
  );

endmodule
